// File: rtl/irps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irps_pkg
// Shared types and constants of the infrared pulse/space decoder.
// ----------------------------------------------------------------------------
package irps_pkg;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 7;
    localparam int PROD_W      = COUNT_W + BYTE_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] LEN_FLIP       = 8'h80;
    localparam logic [BYTE_W-1:0] TIME_UNIT_INIT = 8'd50;

    // One sample handed from the byte parser to the accumulator side.
    typedef struct packed {
        logic              is_pulse;
        logic [PROD_W-1:0] dur;
    } sample_t;

endpackage : irps_pkg
`default_nettype wire

// File: rtl/ir_packet_to_pulse_space_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ir_packet_to_pulse_space_unit
// Infrared receiver byte stream to pulse/space duration words.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle and, at each change between pulse and
// space, delivers the completed duration in microseconds with a pulse flag.
// A byte passes the combinational parser and lands in a two-entry sample
// queue; the accumulator takes one sample per cycle from that queue while
// the output register is empty or being read, and registers its result
// there. Throughput is one byte per cycle as long as results are taken; a
// stalled output fills the queue and then holds in_ready low. Header and
// length bytes never produce a result. Write time_unit only while no bytes
// are in flight.
// ----------------------------------------------------------------------------
module ir_packet_to_pulse_space_unit
    import irps_pkg::*;
#(
    parameter int HEADER_BYTES   = 2,
    parameter int MAX_PACKET_LEN = 4,
    parameter int DURATION_BITS  = 24
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [BYTE_W-1:0]        cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [BYTE_W-1:0]        data_byte,
    input  wire logic                     transfer_start,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [DURATION_BITS-1:0]      duration,
    output logic                          is_pulse
);

    logic    accept;
    logic    push;
    sample_t push_data;
    logic    full;
    logic    q_valid;
    sample_t q_data;
    logic    pop;

    assign cfg_ready = 1'b1;
    assign in_ready  = !full;
    assign accept    = in_valid && in_ready;

    irps_front #(
        .HEADER_BYTES   (HEADER_BYTES),
        .MAX_PACKET_LEN (MAX_PACKET_LEN)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .accept         (accept),
        .data_byte      (data_byte),
        .transfer_start (transfer_start),
        .push           (push),
        .push_data      (push_data)
    );

    irps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop)
    );

    irps_back #(
        .DURATION_BITS (DURATION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .duration  (duration),
        .is_pulse  (is_pulse)
    );

endmodule : ir_packet_to_pulse_space_unit
`default_nettype wire

// File: rtl/irps_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irps_queue
// Short first-in first-out queue of samples between parser and accumulator.
// ----------------------------------------------------------------------------
module irps_queue
    import irps_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire sample_t push_data,
    output logic         full,
    output logic         q_valid,
    output sample_t      q_data,
    input  wire logic    pop
);

    sample_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule : irps_queue
`default_nettype wire

// File: rtl/irps_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irps_front
// Byte parser: skips transfer headers, tracks packet lengths and drops
// overlong transfers, and scales each sample byte by the time unit.
// ----------------------------------------------------------------------------
module irps_front
    import irps_pkg::*;
#(
    parameter int HEADER_BYTES   = 2,
    parameter int MAX_PACKET_LEN = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic [BYTE_W-1:0] cfg_data,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              transfer_start,
    output logic                   push,
    output sample_t                push_data
);

    localparam int HDR_W = (HEADER_BYTES > 0) ? $clog2(HEADER_BYTES + 1) : 1;
    localparam int PKT_W = $clog2(MAX_PACKET_LEN + 1);

    logic [BYTE_W-1:0] time_unit_reg;
    logic [HDR_W-1:0]  header_left_reg, header_left_next;
    logic [PKT_W-1:0]  pkt_left_reg, pkt_left_next;
    logic              discarding_reg, discarding_next;
    logic [HDR_W-1:0]  hdr_eff;
    logic              disc_eff;
    logic [BYTE_W-1:0] len;

    assign len = data_byte ^ LEN_FLIP;

    always_comb
    begin
        hdr_eff          = transfer_start ? HDR_W'(HEADER_BYTES) : header_left_reg;
        disc_eff         = transfer_start ? 1'b0 : discarding_reg;
        header_left_next = hdr_eff;
        discarding_next  = disc_eff;
        pkt_left_next    = pkt_left_reg;
        push             = 1'b0;
        push_data.is_pulse = data_byte[BYTE_W-1];
        push_data.dur      = PROD_W'(data_byte[COUNT_W-1:0]) * PROD_W'(time_unit_reg);
        if (hdr_eff != '0)
        begin
            header_left_next = hdr_eff - 1'b1;
        end
        else if (disc_eff)
        begin
            discarding_next = 1'b1;
        end
        else if (pkt_left_reg == '0)
        begin
            // length byte opens a packet, an overlong one drops the transfer
            if (len > BYTE_W'(MAX_PACKET_LEN))
            begin
                pkt_left_next   = '0;
                discarding_next = 1'b1;
            end
            else
            begin
                pkt_left_next = PKT_W'(len);
            end
        end
        else
        begin
            pkt_left_next = pkt_left_reg - 1'b1;
            push          = accept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_unit_reg   <= TIME_UNIT_INIT;
            header_left_reg <= '0;
            pkt_left_reg    <= '0;
            discarding_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                time_unit_reg <= cfg_data;
            end
            if (accept)
            begin
                header_left_reg <= header_left_next;
                pkt_left_reg    <= pkt_left_next;
                discarding_reg  <= discarding_next;
            end
        end
    end

endmodule : irps_front
`default_nettype wire

// File: rtl/irps_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irps_back
// Accumulator side: merges runs of equal kind with saturation and emits the
// completed duration at each pulse/space change through an output register.
// ----------------------------------------------------------------------------
module irps_back
    import irps_pkg::*;
#(
    parameter int DURATION_BITS = 24
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire sample_t           q_data,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DURATION_BITS-1:0] duration,
    output logic                   is_pulse
);

    localparam logic [DURATION_BITS-1:0] DUR_MAX = '1;

    logic [DURATION_BITS-1:0] pulse_accum_reg, pulse_accum_next;
    logic [DURATION_BITS-1:0] space_accum_reg, space_accum_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DURATION_BITS-1:0] duration_reg, duration_next;
    logic                     is_pulse_reg, is_pulse_next;
    logic [DURATION_BITS-1:0] pulse_base;
    logic [DURATION_BITS:0]   pulse_sum;
    logic [DURATION_BITS:0]   space_sum;
    logic                     emit;

    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign duration  = duration_reg;
    assign is_pulse  = is_pulse_reg;

    always_comb
    begin
        pulse_base = (space_accum_reg != '0) ? '0 : pulse_accum_reg;
        pulse_sum  = {1'b0, pulse_base} + (DURATION_BITS + 1)'(q_data.dur);
        space_sum  = {1'b0, space_accum_reg} + (DURATION_BITS + 1)'(q_data.dur);
    end

    always_comb
    begin
        pulse_accum_next = pulse_accum_reg;
        space_accum_next = space_accum_reg;
        emit             = 1'b0;
        duration_next    = duration_reg;
        is_pulse_next    = is_pulse_reg;
        if (q_data.is_pulse)
        begin
            // an open space closes and the pulse starts afresh
            if (space_accum_reg != '0)
            begin
                emit          = 1'b1;
                duration_next = space_accum_reg;
                is_pulse_next = 1'b0;
            end
            space_accum_next = '0;
            pulse_accum_next = pulse_sum[DURATION_BITS] ? DUR_MAX
                                                        : pulse_sum[DURATION_BITS-1:0];
        end
        else
        begin
            if (pulse_accum_reg != '0 && space_accum_reg == '0)
            begin
                emit          = 1'b1;
                duration_next = pulse_accum_reg;
                is_pulse_next = 1'b1;
                pulse_accum_next = '0;
            end
            space_accum_next = space_sum[DURATION_BITS] ? DUR_MAX
                                                        : space_sum[DURATION_BITS-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_accum_reg <= '0;
            space_accum_reg <= DUR_MAX;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                pulse_accum_reg <= pulse_accum_next;
                space_accum_reg <= space_accum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            duration_reg <= duration_next;
            is_pulse_reg <= is_pulse_next;
        end
    end

endmodule : irps_back
`default_nettype wire

// File: test/pulse_space_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_space_checker
// Watches the byte, configuration and duration channels of the infrared
// pulse/space decoder. It tracks the decoder state on every accepted byte,
// queues the duration words it expects, and compares each delivered word
// field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module pulse_space_checker
    import irps_pkg::*;
#(
    parameter int HEADER_BYTES   = 2,
    parameter int MAX_PACKET_LEN = 4,
    parameter int DURATION_BITS  = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [BYTE_W-1:0]        cfg_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [BYTE_W-1:0]        data_byte,
    input  logic                     transfer_start,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [DURATION_BITS-1:0] duration,
    input  logic                     is_pulse,
    output int                       mismatch_count,
    output int                       durations_pending
);

    typedef struct packed {
        logic [DURATION_BITS-1:0] dur;
        logic                     pulse;
    } duration_word_t;

    localparam logic [DURATION_BITS-1:0] DUR_FULL = '1;

    logic [BYTE_W-1:0]        unit_us;
    logic [DURATION_BITS-1:0] pulse_total;
    logic [DURATION_BITS-1:0] space_total;
    logic [2:0]               pkt_remaining;
    logic [1:0]               header_left;
    logic                     discarding;
    duration_word_t           expected_durations[$];

    initial
    begin
        mismatch_count    = 0;
        durations_pending = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [DURATION_BITS-1:0] sat_sum(
        input logic [DURATION_BITS-1:0] acc,
        input logic [PROD_W-1:0]        add
    );
        logic [DURATION_BITS:0] sum;
        sum = {1'b0, acc} + (DURATION_BITS + 1)'(add);
        return sum[DURATION_BITS] ? DUR_FULL : sum[DURATION_BITS-1:0];
    endfunction

    // Advance the decoder state by one byte; returns 1 when a word closes.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic st,
                                       output duration_word_t word);
        logic [BYTE_W-1:0] len;
        logic [PROD_W-1:0] sample_us;
        bit                emit;
        word = '0;
        emit = 1'b0;
        if (st)
        begin
            discarding  = 1'b0;
            header_left = 2'(HEADER_BYTES);
        end
        if (header_left != 0)
        begin
            header_left--;
            return 1'b0;
        end
        if (discarding)
            return 1'b0;
        if (pkt_remaining == 0)
        begin
            len = b ^ LEN_FLIP;
            if (len > MAX_PACKET_LEN)
            begin
                pkt_remaining = '0;
                discarding    = 1'b1;
            end
            else
                pkt_remaining = 3'(len);
            return 1'b0;
        end
        pkt_remaining--;
        sample_us = PROD_W'(b[COUNT_W-1:0]) * PROD_W'(unit_us);
        if (b[BYTE_W-1])
        begin
            // a pulse closes any open space and starts a fresh pulse, else it extends the pulse
            if (space_total != 0)
            begin
                word.dur    = space_total;
                word.pulse  = 1'b0;
                emit        = 1'b1;
                space_total = '0;
                pulse_total = '0;
            end
            pulse_total = sat_sum(pulse_total, sample_us);
        end
        else
        begin
            if (pulse_total != 0 && space_total == 0)
            begin
                word.dur    = pulse_total;
                word.pulse  = 1'b1;
                emit        = 1'b1;
                pulse_total = '0;
            end
            space_total = sat_sum(space_total, sample_us);
        end
        return emit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        duration_word_t word;
        duration_word_t want;
        if (!rst_n)
        begin
            unit_us       = TIME_UNIT_INIT;
            pulse_total   = '0;
            space_total   = DUR_FULL;
            pkt_remaining = '0;
            header_left   = '0;
            discarding    = 1'b0;
            expected_durations.delete();
            durations_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                unit_us = cfg_data;
            if (in_valid && in_ready)
            begin
                if (decode_byte(data_byte, transfer_start, word))
                    expected_durations.push_back(word);
            end
            if (out_valid && out_ready)
            begin
                if (expected_durations.size() == 0)
                    report_mismatch("duration word with none expected", duration, 0);
                else
                begin
                    want = expected_durations.pop_front();
                    if (duration !== want.dur)
                        report_mismatch("duration mismatch", duration, want.dur);
                    if (is_pulse !== want.pulse)
                        report_mismatch("is_pulse mismatch", is_pulse, want.pulse);
                end
            end
            durations_pending = expected_durations.size();
        end
    end

endmodule : pulse_space_checker

// File: test/ir_packet_to_pulse_space_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_packet_to_pulse_space_unit_tb
// Byte stream stimulus for the infrared pulse/space decoder.
// ----------------------------------------------------------------------------
// A directed sequence walks through headers, zero and overlong lengths,
// zero-time samples, the long leading space and packets split across
// transfers. A long pulse run under the largest time unit follows, then
// random transfers under several time units, among them a long output
// hold-off that backs up the input and a stretch with no idling. The checker
// instance predicts and compares; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module ir_packet_to_pulse_space_unit_tb;
    import irps_pkg::*;

    localparam int HDR           = 2;
    localparam int MAX_LEN       = 4;
    localparam int DUR_W         = 24;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [BYTE_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] data_byte;
    logic              transfer_start;
    logic              out_valid;
    logic              out_ready;
    logic [DUR_W-1:0]  duration;
    logic              is_pulse;

    int fail_count;
    int pending;
    int samples_sent;
    int samples_owed;
    int stall_cycles;
    bit tx_quiet;
    bit rx_quiet;
    bit hold_req;

    ir_packet_to_pulse_space_unit #(
        .HEADER_BYTES   (HDR),
        .MAX_PACKET_LEN (MAX_LEN),
        .DURATION_BITS  (DUR_W)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .transfer_start (transfer_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .duration       (duration),
        .is_pulse       (is_pulse)
    );

    pulse_space_checker #(
        .HEADER_BYTES   (HDR),
        .MAX_PACKET_LEN (MAX_LEN),
        .DURATION_BITS  (DUR_W)
    ) pulse_space_chk (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .data_byte         (data_byte),
        .transfer_start    (transfer_start),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .duration          (duration),
        .is_pulse          (is_pulse),
        .mismatch_count    (fail_count),
        .durations_pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random ready, with an occasional long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready = rx_quiet || ($urandom_range(0, 99) >= 19);
        end
    end

    // Watchdog on cycles with no transfer on any channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic st);
        while (!tx_quiet && $urandom_range(0, 99) < 19)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid       = 1'b1;
        data_byte      = b;
        transfer_start = st;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_sample(input logic [BYTE_W-1:0] b);
        send_byte(b, 1'b0);
        samples_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] rand_sample();
        logic [COUNT_W-1:0] cnt;
        case ($urandom_range(0, 9))
            0:       cnt = '0;
            1:       cnt = '1;
            2, 3:    cnt = COUNT_W'($urandom_range(1, 3));
            default: cnt = COUNT_W'($urandom);
        endcase
        return {1'($urandom), cnt};
    endfunction

    // Start a transfer and finish any packet left open by the previous one.
    task automatic open_transfer();
        int owed;
        send_byte(BYTE_W'($urandom), 1'b1);
        for (int h = 1; h < HDR; h++)
            send_byte(BYTE_W'($urandom), 1'b0);
        owed         = samples_owed;
        samples_owed = 0;
        repeat (owed) send_sample(rand_sample());
    endtask

    task automatic send_random_transfer();
        int                npk;
        int                len;
        logic [BYTE_W-1:0] b;
        open_transfer();
        npk = $urandom_range(1, 4);
        for (int k = 0; k < npk; k++)
        begin
            if ($urandom_range(0, 99) < 6)
            begin
                // overlong length: the rest of the transfer is dropped
                do
                    b = BYTE_W'($urandom);
                while ((b ^ LEN_FLIP) <= MAX_LEN);
                send_byte(b, 1'b0);
                repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom), 1'b0);
                return;
            end
            len = $urandom_range(0, MAX_LEN);
            send_byte(LEN_FLIP | BYTE_W'(len), 1'b0);
            for (int s = 0; s < len; s++)
            begin
                // cut the transfer short, leave the packet open
                if (s > 0 && $urandom_range(0, 99) < 5)
                begin
                    samples_owed = len - s;
                    return;
                end
                send_sample(rand_sample());
            end
        end
    endtask

    task automatic run_random(input int n);
        int target;
        target = samples_sent + n;
        while (samples_sent < target) send_random_transfer();
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_time_unit(input logic [BYTE_W-1:0] v);
        settle();
        cfg_valid = 1'b1;
        cfg_data  = v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        data_byte      = '0;
        transfer_start = 1'b0;
        tx_quiet       = 1'b0;
        rx_quiet       = 1'b0;
        hold_req       = 1'b0;
        samples_sent   = 0;
        samples_owed   = 0;
        stall_cycles   = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset time unit
        send_byte(8'h00, 1'b1); send_byte(8'hFF, 1'b0);
        send_byte(8'h83, 1'b0);
        send_byte(8'h05, 1'b0);      // space on top of the long leading space
        send_byte(8'h81, 1'b0);      // close the saturated space
        send_byte(8'h00, 1'b0);      // zero space still closes the pulse
        send_byte(8'h80, 1'b0);      // zero length
        send_byte(8'h82, 1'b0);
        send_byte(8'h80, 1'b0);      // zero pulse with no space open
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);      // overlong length, drop the transfer
        send_byte(8'h81, 1'b0);
        send_byte(8'h84, 1'b1);
        send_byte(8'h33, 1'b1);      // restart in the middle of the header
        send_byte(8'h7F, 1'b0);
        send_byte(8'h84, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);      // zero pulse still closes the space
        send_byte(8'h83, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h55, 1'b1); send_byte(8'hAA, 1'b0);  // packet spans transfers
        send_byte(8'h90, 1'b0); send_byte(8'h0F, 1'b0);
        send_byte(8'h85, 1'b0);      // just over the maximum length

        // long pulse run under the largest time unit
        write_time_unit(8'd255);
        open_transfer();
        repeat (20)
        begin
            send_byte(LEN_FLIP | BYTE_W'(MAX_LEN), 1'b0);
            repeat (MAX_LEN) send_sample(8'hFF);
        end
        send_byte(LEN_FLIP | 8'd1, 1'b0);
        send_sample(8'h00);

        write_time_unit(8'd1);
        run_random(30);

        write_time_unit(8'd0);
        run_random(20);

        // hold the output while the sender keeps offering bytes
        write_time_unit(BYTE_W'($urandom_range(1, 255)));
        tx_quiet = 1'b1;
        hold_req = 1'b1;
        run_random(40);
        tx_quiet = 1'b0;

        write_time_unit(8'd200);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_random(25);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        write_time_unit(BYTE_W'($urandom));
        run_random(25);

        settle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule : ir_packet_to_pulse_space_unit_tb
